// ===== rtl/log_entries_message_deframer_defines.svh =====
// Assertion macros for the deframer.
`ifndef LOG_ENTRIES_MESSAGE_DEFRAMER_DEFINES_SVH
`define LOG_ENTRIES_MESSAGE_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS
`define LEMD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer assertion failed");
`define LEMD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer assertion failed");
`else
`define LEMD_ASSERT_IMP(lbl, ante, cons)
`define LEMD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/lemd_pkg.sv =====
package lemd_pkg;

	localparam int PHASE_W = 5;
	localparam int KIND_W  = 5;

	localparam logic [PHASE_W-1:0] PH_EPOCH     = 5'd0;
	localparam logic [PHASE_W-1:0] PH_COUNT     = 5'd1;
	localparam logic [PHASE_W-1:0] PH_TYPE      = 5'd2;
	localparam logic [PHASE_W-1:0] PH_STORAGE   = 5'd3;
	localparam logic [PHASE_W-1:0] PH_KEYLEN    = 5'd4;
	localparam logic [PHASE_W-1:0] PH_KEYBYTE   = 5'd5;
	localparam logic [PHASE_W-1:0] PH_VALLEN    = 5'd6;
	localparam logic [PHASE_W-1:0] PH_VALBYTE   = 5'd7;
	localparam logic [PHASE_W-1:0] PH_VMAJOR    = 5'd8;
	localparam logic [PHASE_W-1:0] PH_VMINOR    = 5'd9;
	localparam logic [PHASE_W-1:0] PH_BLOBCOUNT = 5'd10;
	localparam logic [PHASE_W-1:0] PH_BLOBID    = 5'd11;
	localparam logic [PHASE_W-1:0] PH_BLOBSIZE  = 5'd12;
	localparam logic [PHASE_W-1:0] PH_BLOBBYTE  = 5'd13;
	localparam logic [PHASE_W-1:0] PH_FLAGS     = 5'd14;
	localparam logic [PHASE_W-1:0] PH_COMPLETE  = 5'd15;
	localparam logic [PHASE_W-1:0] PH_AWAIT     = 5'd16;
	localparam logic [PHASE_W-1:0] PH_ERROR     = 5'd17;

	localparam logic [KIND_W-1:0] K_REJECTED     = 5'd15;
	localparam logic [KIND_W-1:0] K_TAKEN        = 5'd16;
	localparam logic [KIND_W-1:0] K_TAKE_REFUSED = 5'd17;

	localparam logic [1:0] ST_READING  = 2'd0;
	localparam logic [1:0] ST_COMPLETE = 2'd1;
	localparam logic [1:0] ST_AWAIT    = 2'd2;
	localparam logic [1:0] ST_ERROR    = 2'd3;

	localparam logic OP_DATA = 1'b0;
	localparam logic OP_TAKE = 1'b1;

	localparam logic [2:0] REG_VALID_TYPE_MASK    = 3'd0;
	localparam logic [2:0] REG_SESSION_BEGIN_MASK = 3'd1;
	localparam logic [2:0] REG_SESSION_END_MASK   = 3'd2;
	localparam logic [2:0] REG_FLUSH_MASK         = 3'd3;
	localparam logic [2:0] REG_BLOB_STORE_PRESENT = 3'd4;

	typedef struct packed {
		logic       opcode;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [63:0]       field_value;
		logic              string_last;
		logic              entry_end;
		logic              message_end;
		logic              session_begin;
		logic              session_end;
		logic              flush;
		logic [1:0]        status;
	} rsp_t;

	function automatic logic [3:0] field_bytes(input logic [PHASE_W-1:0] ph);
		logic [3:0] n;
		case (ph)
			PH_EPOCH, PH_STORAGE, PH_VMAJOR, PH_VMINOR, PH_BLOBID: n = 4'd8;
			PH_COUNT, PH_KEYLEN, PH_VALLEN, PH_BLOBCOUNT, PH_BLOBSIZE: n = 4'd4;
			PH_TYPE, PH_FLAGS: n = 4'd1;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

	function automatic logic [1:0] phase_status(input logic [PHASE_W-1:0] ph);
		logic [1:0] s;
		case (ph)
			PH_COMPLETE: s = ST_COMPLETE;
			PH_AWAIT:    s = ST_AWAIT;
			PH_ERROR:    s = ST_ERROR;
			default:     s = ST_READING;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/log_entries_message_deframer.sv =====
// Log-entries message deframer. One word (a wire byte or a take command) is
// accepted per clock cycle while req_ready is high; its result, if any, goes to
// the rsp output register, or to the skid register while rsp is stalled. The
// rate is set by the field update between the parser state registers and
// the output register; a one-entry skid stage keeps req_ready high while one
// finished result waits, so req_ready drops only when two results are held.
// Partial bytes of a multi-byte field give no result. After the flags byte the
// block reports complete and rejects data until a take command restarts it.
`include "log_entries_message_deframer_defines.svh"

module log_entries_message_deframer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  lemd_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output lemd_pkg::rsp_t rsp,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [4:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	import lemd_pkg::*;

	logic [15:0] valid_type_mask_q;
	logic [7:0]  session_begin_mask_q;
	logic [7:0]  session_end_mask_q;
	logic [7:0]  flush_mask_q;
	logic        blob_store_present_q;

	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [63:0] shift_q, shift_d;
	logic [31:0] entries_q, entries_d;
	logic [31:0] blobs_q, blobs_d;
	logic [31:0] bytes_q, bytes_d;
	logic [7:0]  entry_kind_q, entry_kind_d;

	rsp_t rsp_q, skid_q, res;
	logic rsp_valid_q, skid_valid_q;
	logic res_has, accept, cfg_wr;

	logic [63:0] acc_shift;
	logic [2:0]  cnt_inc;
	logic [31:0] bytes_dec, blobs_dec, entries_dec;
	logic        fin_entry, fin_blob, type_ok;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_type_mask_q    <= 16'hFFFF;
			session_begin_mask_q <= 8'd1;
			session_end_mask_q   <= 8'd2;
			flush_mask_q         <= 8'd4;
			blob_store_present_q <= 1'b1;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_VALID_TYPE_MASK:    valid_type_mask_q <= pwdata[15:0];
				REG_SESSION_BEGIN_MASK: session_begin_mask_q <= pwdata[7:0];
				REG_SESSION_END_MASK:   session_end_mask_q <= pwdata[7:0];
				REG_FLUSH_MASK:         flush_mask_q <= pwdata[7:0];
				REG_BLOB_STORE_PRESENT: blob_store_present_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_VALID_TYPE_MASK:    prdata = {16'd0, valid_type_mask_q};
			REG_SESSION_BEGIN_MASK: prdata = {24'd0, session_begin_mask_q};
			REG_SESSION_END_MASK:   prdata = {24'd0, session_end_mask_q};
			REG_FLUSH_MASK:         prdata = {24'd0, flush_mask_q};
			REG_BLOB_STORE_PRESENT: prdata = {31'd0, blob_store_present_q};
			default:                prdata = 32'd0;
		endcase
	end

	assign req_ready = !skid_valid_q;
	assign accept    = req_valid & req_ready;

	always_comb begin
		phase_d      = phase_q;
		cnt_d        = cnt_q;
		shift_d      = shift_q;
		entries_d    = entries_q;
		blobs_d      = blobs_q;
		bytes_d      = bytes_q;
		entry_kind_d = entry_kind_q;
		res          = '0;
		res_has      = 1'b0;
		fin_entry    = 1'b0;
		fin_blob     = 1'b0;
		acc_shift    = {shift_q[55:0], req.data_byte};
		cnt_inc      = cnt_q + 3'd1;
		bytes_dec    = (bytes_q != 32'd0) ? bytes_q - 32'd1 : 32'd0;
		blobs_dec    = blobs_q - 32'd1;
		entries_dec  = entries_q - 32'd1;
		type_ok      = (entry_kind_q[7:4] == 4'd0) && valid_type_mask_q[entry_kind_q[3:0]];

		if (req.opcode == OP_TAKE) begin
			res_has = 1'b1;
			if (phase_q == PH_COMPLETE) begin
				phase_d      = PH_EPOCH;
				cnt_d        = 3'd0;
				shift_d      = 64'd0;
				entries_d    = 32'd0;
				blobs_d      = 32'd0;
				bytes_d      = 32'd0;
				entry_kind_d = 8'd0;
				res.kind     = K_TAKEN;
			end else begin
				res.kind   = K_TAKE_REFUSED;
				res.status = phase_status(phase_q);
			end
		end else if (phase_q >= PH_COMPLETE) begin
			res_has    = 1'b1;
			res.kind   = K_REJECTED;
			res.status = phase_status(phase_q);
		end else if (phase_q inside {PH_KEYBYTE, PH_VALBYTE, PH_BLOBBYTE}) begin
			res_has         = 1'b1;
			res.kind        = phase_q;
			res.field_value = {56'd0, req.data_byte};
			bytes_d         = bytes_dec;
			if (bytes_dec == 32'd0) begin
				res.string_last = 1'b1;
				case (phase_q)
					PH_KEYBYTE: phase_d = PH_VALLEN;
					PH_VALBYTE: phase_d = PH_VMAJOR;
					default:    fin_blob = 1'b1;
				endcase
			end
		end else begin
			shift_d = acc_shift;
			cnt_d   = cnt_inc;
			if (cnt_inc == 3'd0 || {1'b0, cnt_inc} >= field_bytes(phase_q)) begin
				res_has         = 1'b1;
				shift_d         = 64'd0;
				cnt_d           = 3'd0;
				res.kind        = phase_q;
				res.field_value = acc_shift;
				case (phase_q)
					PH_EPOCH: phase_d = PH_COUNT;
					PH_COUNT: begin
						entries_d = acc_shift[31:0];
						phase_d   = (acc_shift[31:0] != 32'd0) ? PH_TYPE : PH_FLAGS;
					end
					PH_TYPE: begin
						entry_kind_d = acc_shift[7:0];
						phase_d      = PH_STORAGE;
					end
					PH_STORAGE: phase_d = PH_KEYLEN;
					PH_KEYLEN: begin
						bytes_d = acc_shift[31:0];
						phase_d = (acc_shift[31:0] != 32'd0) ? PH_KEYBYTE : PH_VALLEN;
					end
					PH_VALLEN: begin
						bytes_d = acc_shift[31:0];
						phase_d = (acc_shift[31:0] != 32'd0) ? PH_VALBYTE : PH_VMAJOR;
					end
					PH_VMAJOR: phase_d = PH_VMINOR;
					PH_VMINOR: phase_d = PH_BLOBCOUNT;
					PH_BLOBCOUNT: begin
						if (acc_shift[31:0] == 32'd0) begin
							fin_entry = 1'b1;
						end else if (blob_store_present_q) begin
							blobs_d = acc_shift[31:0];
							phase_d = PH_BLOBID;
						end else begin
							phase_d    = PH_AWAIT;
							res.status = ST_AWAIT;
						end
					end
					PH_BLOBID: phase_d = PH_BLOBSIZE;
					PH_BLOBSIZE: begin
						if (acc_shift[31:0] == 32'd0) begin
							fin_blob = 1'b1;
						end else begin
							bytes_d = acc_shift[31:0];
							phase_d = PH_BLOBBYTE;
						end
					end
					default: begin
						res.message_end   = 1'b1;
						res.session_begin = (acc_shift[7:0] & session_begin_mask_q) != 8'd0;
						res.session_end   = (acc_shift[7:0] & session_end_mask_q) != 8'd0;
						res.flush         = (acc_shift[7:0] & flush_mask_q) != 8'd0;
						res.status        = ST_COMPLETE;
						phase_d           = PH_COMPLETE;
					end
				endcase
			end
		end

		if (fin_blob) begin
			blobs_d = blobs_dec;
			if (blobs_dec == 32'd0) begin
				fin_entry = 1'b1;
			end else begin
				phase_d = PH_BLOBID;
			end
		end

		if (fin_entry) begin
			if (!type_ok) begin
				phase_d    = PH_ERROR;
				res.status = ST_ERROR;
			end else begin
				entries_d     = entries_dec;
				res.entry_end = 1'b1;
				phase_d       = (entries_dec == 32'd0) ? PH_FLAGS : PH_TYPE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_EPOCH;
			cnt_q        <= 3'd0;
			shift_q      <= 64'd0;
			entries_q    <= 32'd0;
			blobs_q      <= 32'd0;
			bytes_q      <= 32'd0;
			entry_kind_q <= 8'd0;
		end else if (accept) begin
			phase_q      <= phase_d;
			cnt_q        <= cnt_d;
			shift_q      <= shift_d;
			entries_q    <= entries_d;
			blobs_q      <= blobs_d;
			bytes_q      <= bytes_d;
			entry_kind_q <= entry_kind_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!rsp_valid_q || rsp_ready) begin
			if (skid_valid_q) begin
				rsp_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				rsp_valid_q <= accept & res_has;
			end
		end else if (accept & res_has) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!rsp_valid_q || rsp_ready) begin
			if (skid_valid_q) begin
				rsp_q <= skid_q;
			end else if (accept & res_has) begin
				rsp_q <= res;
			end
		end else if (accept & res_has) begin
			skid_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`LEMD_ASSERT_IMP(a_skid_behind_out, skid_valid_q, rsp_valid_q)
	`LEMD_ASSERT_NXT(a_skid_drains, skid_valid_q && rsp_ready, !skid_valid_q)
	`LEMD_ASSERT_IMP(a_end_is_complete, rsp_valid && rsp.message_end, rsp.status == ST_COMPLETE)
	`LEMD_ASSERT_NXT(a_halt_holds, accept && req.opcode == OP_DATA && phase_q >= PH_COMPLETE, $stable(phase_q))
	`LEMD_ASSERT_NXT(a_take_restarts, accept && req.opcode == OP_TAKE && phase_q == PH_COMPLETE, phase_q == PH_EPOCH)

endmodule
